>>> hw/rtl/utf8_stream_decoder_assert.svh
// ---------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent assertion wrappers clocked on clk_i; U8SD_ASSERT is off in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/u8sd_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 stream decoder package
// Payload types, the result-run descriptor and the value check.
// ---------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] FALLBACK_RESET = 21'h00FFFD;
  localparam logic [CpWidth-1:0] CP_MAX         = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               replaced;
    logic [2:0]         bytes_used;
    logic               last_of_run;
  } out_t;

  // All results of one byte: fb_cnt fallbacks, then optionally one decoded value.
  typedef struct packed {
    logic [2:0]         fb_cnt;
    logic               has_cp;
    logic [CpWidth-1:0] cp;
    logic [2:0]         used;
  } run_t;

  function automatic logic value_ok(logic [CpWidth-1:0] cp, logic [2:0] len);
    logic ok;
    ok = 1'b0;
    unique case (len)
      3'd2:    ok = (cp >= 21'h000080);
      3'd3:    ok = (cp >= 21'h000800) && !((cp >= 21'h00D800) && (cp <= 21'h00DFFF));
      3'd4:    ok = (cp >= 21'h010000) && (cp <= CP_MAX);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Validating UTF-8 to code point decoder with one fallback per bad byte.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake               Payload
//  in       in   in_valid_i/in_ready_o   u8sd_pkg::in_t  (text_byte, end_of_text)
//  out      out  out_valid_o/out_ready_i u8sd_pkg::out_t (code_point .. last_of_run)
//  cfg      in   cfg_valid_i/cfg_ready_o fallback code point, 21 bits
//
// A byte is accepted every cycle while each byte gives at most one result and
// the output is not stalled. A byte that gives several results holds the
// result register until its last result is taken, which sets the rate during
// error flushes; results reach the output through the input register, then
// the result register.
// Reset closes any open sequence and restores the fallback to U+FFFD.
// Output stalls back up through the result register into the input register.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire u8sd_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output u8sd_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [20:0]    cfg_data_i
);

  logic           in_valid_q;
  u8sd_pkg::in_t  in_data_q;
  logic [20:0]    fallback_q;
  u8sd_pkg::run_t run;
  logic           run_any;
  logic           emit_free;
  logic           advance;

  // The byte leaves the input register once its results have somewhere to go.
  assign advance    = in_valid_q && (!run_any || emit_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= u8sd_pkg::FALLBACK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fallback_q <= cfg_data_i;
    end
  end

  u8sd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_data_q),
    .take_i    (advance),
    .run_o     (run),
    .run_any_o (run_any)
  );

  u8sd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (run),
    .push_i      (advance && run_any),
    .free_o      (emit_free),
    .fallback_i  (fallback_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `include "utf8_stream_decoder_assert.svh"

  `U8SD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result shown straight after reset")
  `U8SD_ASSERT(a_ready_when_empty, !in_valid_q |-> in_ready_o, "input register empty but not ready")
  `U8SD_ASSERT(a_hold_on_stall, (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q)), "pending byte lost while stalled")

endmodule

`default_nettype wire

>>> hw/rtl/u8sd_decode.sv
// ---------------------------------------------------------------------------
// UTF-8 stream decoder: byte decode
// Holds the open-sequence state and turns one byte into a run of results.
// ---------------------------------------------------------------------------
`default_nettype none

module u8sd_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire u8sd_pkg::in_t in_i,
  input  wire logic          take_i,
  output u8sd_pkg::run_t     run_o,
  output logic               run_any_o
);

  logic [1:0]  pc_q, pc_d;
  logic [2:0]  sl_q, sl_d;
  logic [20:0] acc_q, acc_d;

  logic [7:0]  b;
  logic        cont;
  logic        opened;
  logic [2:0]  pc_next;
  logic [20:0] acc_ext;

  assign b       = in_i.text_byte;
  assign cont    = (b[7:6] == 2'b10);
  assign pc_next = {1'b0, pc_q} + 3'd1;
  assign acc_ext = {acc_q[14:0], b[5:0]};

  always_comb begin
    pc_d         = pc_q;
    sl_d         = sl_q;
    acc_d        = acc_q;
    opened       = 1'b0;
    run_o.fb_cnt = 3'd0;
    run_o.has_cp = 1'b0;
    run_o.cp     = '0;
    run_o.used   = 3'd1;

    if ((pc_q != 2'd0) && cont) begin
      if (pc_next >= sl_q) begin
        if (u8sd_pkg::value_ok(acc_ext, sl_q)) begin
          run_o.has_cp = 1'b1;
          run_o.cp     = acc_ext;
          run_o.used   = sl_q;
        end else begin
          run_o.fb_cnt = sl_q;
        end
        pc_d  = 2'd0;
        sl_d  = 3'd0;
        acc_d = '0;
      end else begin
        pc_d   = pc_next[1:0];
        acc_d  = acc_ext;
        opened = 1'b1;
      end
    end else begin
      // Any held bytes of a broken sequence fall back first; the byte then
      // starts afresh as a lead.
      run_o.fb_cnt = {1'b0, pc_q};
      pc_d  = 2'd0;
      sl_d  = 3'd0;
      acc_d = '0;
      priority if (!b[7]) begin
        run_o.has_cp = 1'b1;
        run_o.cp     = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        pc_d   = 2'd1;
        sl_d   = 3'd2;
        acc_d  = {16'd0, b[4:0]};
        opened = 1'b1;
      end else if (b[7:4] == 4'b1110) begin
        pc_d   = 2'd1;
        sl_d   = 3'd3;
        acc_d  = {17'd0, b[3:0]};
        opened = 1'b1;
      end else if (b[7:3] == 5'b11110) begin
        pc_d   = 2'd1;
        sl_d   = 3'd4;
        acc_d  = {18'd0, b[2:0]};
        opened = 1'b1;
      end else begin
        run_o.fb_cnt = run_o.fb_cnt + 3'd1;
      end
    end

    if (in_i.end_of_text && opened) begin
      run_o.fb_cnt = run_o.fb_cnt + {1'b0, pc_d};
      pc_d  = 2'd0;
      sl_d  = 3'd0;
      acc_d = '0;
    end
  end

  assign run_any_o = run_o.has_cp || (run_o.fb_cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= 2'd0;
      sl_q  <= 3'd0;
      acc_q <= '0;
    end else if (take_i) begin
      pc_q  <= pc_d;
      sl_q  <= sl_d;
      acc_q <= acc_d;
    end
  end

  `include "utf8_stream_decoder_assert.svh"

  `U8SD_ASSERT(a_open_len_valid, (pc_q != 2'd0) |-> ((sl_q >= 3'd2) && (sl_q <= 3'd4) && ({1'b0, pc_q} < sl_q)), "open sequence length out of range")
  `U8SD_ASSERT(a_closed_clear, (pc_q == 2'd0) |-> ((sl_q == 3'd0) && (acc_q == 21'd0)), "closed sequence left state behind")
  `U8SD_ASSERT(a_run_bound, take_i |-> (({1'b0, run_o.fb_cnt} + {3'd0, run_o.has_cp}) <= 4'd4), "more than four results for one byte")

endmodule

`default_nettype wire

>>> hw/rtl/u8sd_emit.sv
// ---------------------------------------------------------------------------
// UTF-8 stream decoder: result emitter
// Holds one byte's results and hands out one a cycle while out_ready_i holds.
// ---------------------------------------------------------------------------
`default_nettype none

module u8sd_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire u8sd_pkg::run_t run_i,
  input  wire logic           push_i,
  output logic                free_o,
  input  wire logic [20:0]    fallback_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output u8sd_pkg::out_t      out_data_o
);

  logic           valid_q;
  logic [2:0]     fb_q;
  u8sd_pkg::run_t run_q;
  logic           last;
  logic           hand;
  logic           done;

  assign last = (fb_q == 3'd0) || ((fb_q == 3'd1) && !run_q.has_cp);
  assign hand = valid_q && out_ready_i;
  assign done = hand && last;

  // The register can take a new run in the same cycle its last result leaves.
  assign free_o = !valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fb_q    <= 3'd0;
    end else if (push_i) begin
      valid_q <= 1'b1;
      fb_q    <= run_i.fb_cnt;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (hand) begin
      fb_q <= fb_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      run_q <= run_i;
    end
  end

  assign out_valid_o = valid_q;

  always_comb begin
    if (fb_q != 3'd0) begin
      out_data_o.code_point = fallback_i;
      out_data_o.replaced   = 1'b1;
      out_data_o.bytes_used = 3'd1;
    end else begin
      out_data_o.code_point = run_q.cp;
      out_data_o.replaced   = 1'b0;
      out_data_o.bytes_used = run_q.used;
    end
    out_data_o.last_of_run = last;
  end

  `include "utf8_stream_decoder_assert.svh"

  `U8SD_ASSERT(a_run_not_empty, valid_q |-> ((fb_q != 3'd0) || run_q.has_cp), "held run has no result left")
  `U8SD_ASSERT(a_fb_bound, fb_q <= 3'd4, "fallback count above four")
  `U8SD_ASSERT(a_drop_after_last, (done && !push_i) |=> !valid_q, "run register still valid after its last transaction")
  `U8SD_ASSERT(a_decoded_in_range, (valid_q && (fb_q == 3'd0)) |-> (run_q.cp <= u8sd_pkg::CP_MAX), "decoded value above the Unicode range")

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Streams directed and random UTF-8 text through the decoder under several
// flow-control patterns and fallback settings. Each result transaction is
// checked against a behavioural decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned HoldCycles     = 150;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned PhaseBytes     = 105;
  localparam int unsigned MaxReports     = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  u8sd_pkg::in_t         in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  u8sd_pkg::out_t        out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [20:0]           cfg_data_i = '0;

  utf8_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Text waiting to be sent and code points waiting to come back.
  u8sd_pkg::in_t  pending_bytes[$];
  u8sd_pkg::out_t expected_cps[$];
  u8sd_pkg::out_t byte_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_request = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  int unsigned queued_bytes = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned fallbacks_seen = 0;
  int unsigned multibyte_seen = 0;
  int unsigned mismatches = 0;

  // Decoder state mirrored by the testbench.
  logic [1:0]  held_bytes = '0;
  logic [2:0]  seq_len = '0;
  logic [20:0] seq_bits = '0;
  logic [20:0] fallback_cp = u8sd_pkg::FALLBACK_RESET;

  function automatic void emit(logic [20:0] cp, logic rep, logic [2:0] used);
    u8sd_pkg::out_t r;
    r.code_point  = cp;
    r.replaced    = rep;
    r.bytes_used  = used;
    r.last_of_run = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void emit_fallbacks(int unsigned count);
    for (int unsigned i = 0; i < count; i++) emit(fallback_cp, 1'b1, 3'd1);
  endfunction

  function automatic void close_sequence();
    held_bytes = '0;
    seq_len    = '0;
    seq_bits   = '0;
  endfunction

  function automatic void open_lead(logic [7:0] b);
    if (b[7] == 1'b0) begin
      emit({13'd0, b}, 1'b0, 3'd1);
    end else if (b[7:5] == 3'b110) begin
      held_bytes = 2'd1;
      seq_len    = 3'd2;
      seq_bits   = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      held_bytes = 2'd1;
      seq_len    = 3'd3;
      seq_bits   = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      held_bytes = 2'd1;
      seq_len    = 3'd4;
      seq_bits   = {18'd0, b[2:0]};
    end else begin
      emit_fallbacks(1);
    end
  endfunction

  // Works out every code point that one text byte releases and queues them.
  function automatic void decode_byte(u8sd_pkg::in_t item);
    logic [7:0]     b;
    logic           ok;
    u8sd_pkg::out_t r;
    b = item.text_byte;
    byte_results.delete();
    if (held_bytes != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_bits = {seq_bits[14:0], b[5:0]};
        if (held_bytes + 1 >= seq_len) begin
          case (seq_len)
            3'd2:    ok = seq_bits >= 21'h000080;
            3'd3:    ok = seq_bits >= 21'h000800 &&
                          !(seq_bits >= 21'h00D800 && seq_bits <= 21'h00DFFF);
            3'd4:    ok = seq_bits >= 21'h010000 && seq_bits <= 21'h10FFFF;
            default: ok = 1'b0;
          endcase
          if (ok) emit(seq_bits, 1'b0, seq_len);
          else emit_fallbacks(seq_len);
          close_sequence();
        end else begin
          held_bytes = held_bytes + 2'd1;
        end
      end else begin
        // The breaking byte is decoded afresh after the held bytes are flushed.
        emit_fallbacks(held_bytes);
        close_sequence();
        open_lead(b);
      end
    end else begin
      open_lead(b);
    end
    if (item.end_of_text && held_bytes != 0) begin
      emit_fallbacks(held_bytes);
      close_sequence();
    end
    foreach (byte_results[i]) begin
      r = byte_results[i];
      r.last_of_run = (i == byte_results.size() - 1);
      expected_cps.push_back(r);
    end
  endfunction

  // Sender: presents queued bytes and holds each one until its transaction.
  always @(posedge clk_i) begin : drive_text
    logic offer;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_data_i);
        void'(pending_bytes.pop_front());
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        offer = pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct;
        in_valid_i <= offer;
        if (offer) in_data_i <= pending_bytes[0];
      end
    end
  end

  // Long receiver hold-off, so that the decoder fills and stalls its input.
  always @(posedge clk_i) begin : hold_off
    if (hold_request && !hold_taken) begin
      hold_left  <= HoldCycles;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : check_results
    u8sd_pkg::out_t want;
    u8sd_pkg::out_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        results_checked++;
        if (got.replaced) fallbacks_seen++;
        if (got.bytes_used > 1) multibyte_seen++;
        if (expected_cps.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: cp=%06h rep=%0b used=%0d last=%0b",
                     got.code_point, got.replaced, got.bytes_used, got.last_of_run);
        end else begin
          want = expected_cps.pop_front();
          if (got.code_point !== want.code_point || got.replaced !== want.replaced ||
              got.bytes_used !== want.bytes_used ||
              got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"result %0d mismatch: expected cp=%06h rep=%0b used=%0d last=%0b,",
                        " got cp=%06h rep=%0b used=%0d last=%0b"}, results_checked,
                       want.code_point, want.replaced, want.bytes_used, want.last_of_run,
                       got.code_point, got.replaced, got.bytes_used, got.last_of_run);
          end
        end
      end
      out_ready_i <= hold_left == 0 && $urandom_range(99) >= sink_stall_pct;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic eot);
    u8sd_pkg::in_t item;
    item.text_byte   = b;
    item.end_of_text = eot;
    pending_bytes.push_back(item);
    queued_bytes++;
  endtask

  // Pushes the first keep bytes of the len-byte encoding of cp.
  task automatic push_encoded(logic [20:0] cp, int unsigned len, int unsigned keep);
    logic [7:0]  b;
    logic [20:0] part;
    for (int unsigned k = 0; k < keep; k++) begin
      if (k == 0) begin
        case (len)
          1:       b = cp[7:0];
          2:       b = {3'b110, cp[10:6]};
          3:       b = {4'b1110, cp[15:12]};
          default: b = {5'b11110, cp[20:18]};
        endcase
      end else begin
        part = cp >> (6 * (len - 1 - k));
        b = {2'b10, part[5:0]};
      end
      push_byte(b, $urandom_range(99) < 4);
    end
  endtask

  task automatic random_text(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [20:0] cp;
    stop_at = queued_bytes + count;
    while (queued_bytes < stop_at) begin
      pick = $urandom_range(99);
      len  = $urandom_range(4, 1);
      case (len)
        1:       cp = $urandom_range(21'h00007F, 0);
        2:       cp = $urandom_range(21'h0007FF, 21'h000080);
        3:       cp = $urandom_range(21'h00FFFF, 21'h000800);
        default: cp = $urandom_range(21'h10FFFF, 21'h010000);
      endcase
      // Surrogates are moved out of the way for well-formed text.
      if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h002000;
      if (pick < 60) begin
        push_encoded(cp, len, len);
      end else if (pick < 72) begin
        // Complete sequences carrying an overlong, surrogate or too large value.
        len = $urandom_range(4, 2);
        case (len)
          2:       cp = $urandom_range(21'h00007F, 0);
          3:       cp = $urandom_range(1) ? $urandom_range(21'h0007FF, 0) :
                                            $urandom_range(21'h00DFFF, 21'h00D800);
          default: cp = $urandom_range(1) ? $urandom_range(21'h00FFFF, 0) :
                                            $urandom_range(21'h1FFFFF, 21'h110000);
        endcase
        push_encoded(cp, len, len);
      end else if (pick < 82) begin
        if (len == 1) len = 2;
        push_encoded(cp, len, $urandom_range(len - 1, 1));
      end else begin
        push_byte($urandom_range(255), $urandom_range(99) < 6);
      end
    end
  endtask

  // Waits until every byte has been taken and every code point returned.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_cps.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_fallback(logic [20:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fallback_cp = value;
  endtask

  task automatic run_phase(logic [20:0] fallback, int unsigned send_pct,
                           int unsigned sink_pct, logic with_hold);
    write_fallback(fallback);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    sink_stall_pct = sink_pct;
    hold_request   = with_hold;
    random_text(PhaseBytes);
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed text with the reset fallback and no idling.
    push_byte(8'h00, 1'b0);                          // zero byte decodes as U+0000
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b0);  // smallest two-byte value
    push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);  // U+10FFFF
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b0);                          // surrogate
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);  // overlong
    push_byte(8'h80, 1'b0);                          // stray continuation
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF8, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h41, 1'b0);  // three held bytes broken by 'A'
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);  // flushed by end of text
    push_byte(8'h41, 1'b1);
    wait_idle();

    run_phase(21'h1FFFFF, 0, 0, 1'b1);
    run_phase(21'h000000, 53, 0, 1'b0);
    run_phase(21'($urandom_range(21'h1FFFFF, 0)), 0, 53, 1'b0);
    run_phase(u8sd_pkg::FALLBACK_RESET, 25, 25, 1'b0);

    $display("Sent %0d text bytes and checked %0d code points (%0d multi-byte, %0d fallbacks).",
             bytes_sent, results_checked, multibyte_seen, fallbacks_seen);
    $display("Covered five flow-control patterns, a long output hold-off and four fallback values.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/u8sd_emit.sv
hw/rtl/utf8_stream_decoder.sv
sim/tb.sv
